### sv/sha_pkg.sv
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic        load_word;
        t_word       word;
        logic        start;
        logic        reset_hash;
        logic [2:0]  out_idx;
    } t_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
    } t_status;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### sv/sha_datapath.sv
module sha_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_cmd     i_cmd,
    output sha_pkg::t_status  o_status,
    output sha_pkg::t_word    o_hash_word
);
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [3:0]     r_fill;
    logic [5:0]     r_round;
    logic           r_busy;
    logic           r_done;

    sha_pkg::t_word a, e, big0, big1, ch, maj, t1, t2, s0, s1, w_new, w_cur;

    always_comb begin
        a     = r_v[0];
        e     = r_v[4];
        big1  = sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25);
        ch    = (e & r_v[5]) ^ (~e & r_v[6]);
        big0  = sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22);
        maj   = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_cur = r_w[0];
        t1    = r_v[7] + big1 + ch + sha_pkg::ROUND_K[r_round] + w_cur;
        t2    = big0 + maj;
        s0    = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= sha_pkg::INIT_H;
            r_fill <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.reset_hash) begin
                r_h    <= sha_pkg::INIT_H;
                r_fill <= '0;
            end
            if (i_cmd.load_word) begin
                r_w[r_fill] <= i_cmd.word;
                r_fill      <= r_fill + 4'd1;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_v     <= r_h;
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_status.busy = r_busy | r_done;
    assign o_status.done = r_done;
    assign o_hash_word   = r_h[i_cmd.out_idx];
endmodule

### sv/sha_ctrl.sv
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_data_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_last_word,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_word_index,
    output logic              o_last_result,
    output sha_pkg::t_cmd     o_cmd,
    input  sha_pkg::t_status  i_status
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic        r_mark, n_mark;
    logic        r_hi, n_hi;
    logic [2:0]  r_idx, n_idx;

    logic [2:0]  cnt;
    logic        last;
    logic [31:0] keep, dw;
    logic        acc;

    always_comb begin
        cnt  = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        last = i_last_word | (cnt != 3'd0 && cnt != 3'd4);
        case (cnt)
            3'd0:    keep = 32'h0;
            3'd1:    keep = 32'hff000000;
            3'd2:    keep = 32'hffff0000;
            3'd3:    keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        dw = i_data_word & keep;
        case (cnt)
            3'd0:    dw = 32'h80000000;
            3'd1:    dw = dw | 32'h00800000;
            3'd2:    dw = dw | 32'h00008000;
            3'd3:    dw = dw | 32'h00000080;
            default: dw = dw;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !i_status.busy;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_len   = r_len;
        n_mark  = r_mark;
        n_hi    = r_hi;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.out_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (cnt != 3'd0 || last)) begin
                    n_len = r_len + {58'd0, cnt, 3'd0};
                    o_cmd.load_word = 1'b1;
                    o_cmd.word = dw;
                    o_cmd.start = (r_fill == 4'd15);
                    n_fill = r_fill + 4'd1;
                    if (last) begin
                        n_mark = (cnt == 3'd4);
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!i_status.busy) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.start = (r_fill == 4'd15);
                    n_fill = r_fill + 4'd1;
                    if (r_mark) begin
                        o_cmd.word = 32'h80000000;
                        n_mark = 1'b0;
                    end else if (r_fill == 4'd14 && !r_hi) begin
                        o_cmd.word = r_len[63:32];
                        n_hi = 1'b1;
                    end else if (r_fill == 4'd15 && r_hi) begin
                        o_cmd.word = r_len[31:0];
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.word = 32'h0;
                    end
                end
            end
            S_WAIT: begin
                if (i_status.done) begin
                    n_state = S_OUT;
                    n_idx = 3'd0;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                        n_fill = '0;
                        n_len = '0;
                        n_mark = 1'b0;
                        n_hi = 1'b0;
                        n_idx = '0;
                        o_cmd.reset_hash = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_word_index  = r_idx;
    assign o_last_result = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_mark  <= 1'b0;
            r_hi    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_mark  <= n_mark;
            r_hi    <= n_hi;
            r_idx   <= n_idx;
        end
    end
endmodule

### sv/sha256_hash.sv
// Channel | Signals                                        | Direction
// input   | i_valid o_ready i_data_word i_byte_count i_last_word | in
// output  | o_valid i_ready o_digest_word o_word_index o_last_result | out
// Each sixteenth word starts a compression, one round per cycle in
// the shared round unit, followed by a fold into the chaining hash.
// Padding words are loaded after the final transfer, pausing while a compression runs.
// Input is not taken while padding is loaded, a compression runs or the digest is being sent.
// Reset restores the initial hash values and clears the length count.
module sha256_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_result
);
    sha_pkg::t_cmd    cmd;
    sha_pkg::t_status status;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_word, .i_byte_count,
        .i_last_word, .o_valid, .i_ready, .o_word_index, .o_last_result,
        .o_cmd(cmd), .i_status(status)
    );

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .o_hash_word(o_digest_word)
    );
endmodule
